@@ hw/rtl/srms_pkg.sv @@
// ----------------------------------------------------------------------------
// Swing reversal motor sequencer package
// Shared types, register codes and fixed constants of the sequencer.
// ----------------------------------------------------------------------------
package srms_pkg;

  // Event kinds carried by an input transfer.
  typedef enum logic [1:0] {
    MODE_EDGE  = 2'd0,
    MODE_INDEX = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Sequence phases.
  typedef enum logic [1:0] {
    PH_PUMP  = 2'd0,
    PH_SWING = 2'd1,
    PH_BRAKE = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_TIME    = 3'd0,
    REG_MIN_HOLD      = 3'd1,
    REG_SWING_TIMEOUT = 3'd2,
    REG_BRAKE         = 3'd3,
    REG_PUMP_TARGET   = 3'd4,
    REG_WIDE_LIMIT    = 3'd5,
    REG_INDEX_POS     = 3'd6
  } cfg_reg_e;

  // Field widths.
  localparam int unsigned TimeW     = 32;
  localparam int unsigned PosW      = 16;
  localparam int unsigned HoldW     = 16;
  localparam int unsigned LimitW    = 15;
  localparam int unsigned LockW     = 20;
  localparam int unsigned HistDepth = 5;

  localparam logic [LockW-1:0] LockMax = '1;

  // Reset values of the configuration registers and the lockout.
  localparam logic [TimeW-1:0]       StartTimeRst    = 32'd0;
  localparam logic [HoldW-1:0]       MinHoldRst      = 16'd500;
  localparam logic [HoldW-1:0]       SwingTimeoutRst = 16'd6000;
  localparam logic [HoldW-1:0]       BrakeRst        = 16'd3000;
  localparam logic signed [PosW-1:0] PumpTargetRst   = 16'sd10;
  localparam logic [LimitW-1:0]      WideLimitRst    = 15'd40;
  localparam logic signed [PosW-1:0] IndexPosRst     = 16'sd6;
  localparam logic [LockW-1:0]       LockRst         = 20'd500;

  // Pump timing: an initial hold, then a square wave of a fixed period.
  localparam logic [TimeW-1:0] StartHoldMs   = 32'd1000;
  localparam logic [TimeW-1:0] PumpPeriodMs  = 32'd1200;
  localparam logic [TimeW-1:0] PumpHalfMs    = 32'd600;
  localparam logic [TimeW-1:0] IndexSettleMs = 32'd1;

  // Quotient by the pump period: 1200 = 75 * 16, and x / 75 for a 28-bit x
  // is exact as (x * ceil(2^35 / 75)) >> 35.
  localparam int unsigned PeriodShift = 4;
  localparam int unsigned RecipW      = 29;
  localparam logic [RecipW-1:0] RecipMul = 29'd458129845;
  localparam int unsigned RecipShift  = 35;
  localparam int unsigned QuoW        = 22;
  localparam int unsigned ProdW       = TimeW - PeriodShift + RecipW;

  // Configuration as seen by the core.
  typedef struct packed {
    logic [TimeW-1:0]       start_time;
    logic [HoldW-1:0]       min_hold;
    logic [HoldW-1:0]       swing_timeout;
    logic [HoldW-1:0]       brake;
    logic signed [PosW-1:0] pump_target;
    logic [LimitW-1:0]      wide_limit;
    logic signed [PosW-1:0] index_pos;
  } cfg_t;

  // One event.
  typedef struct packed {
    mode_e            mode;
    logic [TimeW-1:0] time_ms;
    logic             index_level;
    logic             stop_pressed;
  } evt_t;

  // Event with its pump-period quotient, handed from the front to the core.
  typedef struct packed {
    logic            valid;
    evt_t            evt;
    logic [QuoW-1:0] quo;
  } item_t;

  // One result.
  typedef struct packed {
    logic                   motor_enable;
    logic                   motor_dir;
    logic                   led_swing;
    logic                   led_done;
    logic                   led_index;
    logic signed [PosW-1:0] position;
    phase_e                 phase;
    logic [LockW-1:0]       hold_time;
  } res_t;

endpackage

@@ hw/rtl/srms_evt_if.sv @@
// ----------------------------------------------------------------------------
// Event channel
// Valid/ready channel that carries one timestamped event per transfer.
// ----------------------------------------------------------------------------
interface srms_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] time_ms;
  logic        index_level;
  logic        stop_pressed;

  modport source (output valid, mode, time_ms, index_level, stop_pressed, input ready);
  modport sink   (input valid, mode, time_ms, index_level, stop_pressed, output ready);
endinterface

@@ hw/rtl/srms_res_if.sv @@
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the motor outputs after each event.
// ----------------------------------------------------------------------------
interface srms_res_if;
  logic               valid;
  logic               ready;
  logic               motor_enable;
  logic               motor_dir;
  logic               led_swing;
  logic               led_done;
  logic               led_index;
  logic signed [15:0] position;
  logic [1:0]         phase;
  logic [19:0]        hold_time;

  modport source (output valid, motor_enable, motor_dir, led_swing, led_done, led_index,
                  position, phase, hold_time, input ready);
  modport sink   (input valid, motor_enable, motor_dir, led_swing, led_done, led_index,
                  position, phase, hold_time, output ready);
endinterface

@@ hw/rtl/srms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Sequencer configuration registers
// Write-only register file loaded through a plain write port.
// ----------------------------------------------------------------------------
module srms_cfg_regs
  import srms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_d, cfg_q;

  // Decode the write; indexes beyond the list leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_TIME:    cfg_d.start_time    = cfg_data_i;
        REG_MIN_HOLD:      cfg_d.min_hold      = cfg_data_i[HoldW-1:0];
        REG_SWING_TIMEOUT: cfg_d.swing_timeout = cfg_data_i[HoldW-1:0];
        REG_BRAKE:         cfg_d.brake         = cfg_data_i[HoldW-1:0];
        REG_PUMP_TARGET:   cfg_d.pump_target   = $signed(cfg_data_i[PosW-1:0]);
        REG_WIDE_LIMIT:    cfg_d.wide_limit    = cfg_data_i[LimitW-1:0];
        REG_INDEX_POS:     cfg_d.index_pos     = $signed(cfg_data_i[PosW-1:0]);
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_time    <= StartTimeRst;
      cfg_q.min_hold      <= MinHoldRst;
      cfg_q.swing_timeout <= SwingTimeoutRst;
      cfg_q.brake         <= BrakeRst;
      cfg_q.pump_target   <= PumpTargetRst;
      cfg_q.wide_limit    <= WideLimitRst;
      cfg_q.index_pos     <= IndexPosRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/srms_front.sv @@
// ----------------------------------------------------------------------------
// Sequencer front end
// Input register, then a reciprocal multiply that finds the pump-period
// quotient of the timestamp, registered before it reaches the core.
// ----------------------------------------------------------------------------
module srms_front
  import srms_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  evt_t  in_evt_i,
  output item_t item_o,
  input  logic  item_ready_i
);

  logic            s1_valid_q;
  evt_t            s1_evt_q;
  logic            s2_valid_q;
  evt_t            s2_evt_q;
  logic [QuoW-1:0] s2_quo_q;
  logic            s1_ready;
  logic            s2_ready;
  logic [ProdW-1:0] prod;

  // Each stage takes a new transfer when it is empty or drains this cycle.
  assign s2_ready   = !s2_valid_q || item_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Quotient of the timestamp by the pump period.
  assign prod = ProdW'(s1_evt_q.time_ms[TimeW-1:PeriodShift]) * ProdW'(RecipMul);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_evt_q <= in_evt_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_evt_q <= s1_evt_q;
      s2_quo_q <= prod[RecipShift +: QuoW];
    end
  end

  assign item_o.valid = s2_valid_q;
  assign item_o.evt   = s2_evt_q;
  assign item_o.quo   = s2_quo_q;

endmodule

@@ hw/rtl/srms_core.sv @@
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the sequencer state, applies one event per cycle while the result
// register can take it, and registers the resulting motor outputs.
// ----------------------------------------------------------------------------
module srms_core
  import srms_pkg::*;
#(
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  output logic  item_ready_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  localparam int unsigned IntW  = INTERVAL_BITS;
  localparam int unsigned SumW  = IntW + 4;
  localparam int unsigned WideW = (SumW > LockW) ? SumW : LockW;
  localparam logic [IntW-1:0] IntCap = '1;

  // State.
  logic [PosW-1:0]  pos_q, pos_d;
  logic             dir_q, dir_d;
  logic             pin_q, pin_d;
  logic [IntW-1:0]  hist_q [HistDepth];
  logic [IntW-1:0]  hist_d [HistDepth];
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic [TimeW-1:0] last_rev_q, last_rev_d;
  logic [LockW-1:0] lock_q, lock_d;
  phase_e           phase_q, phase_d;
  logic             pend_q, pend_d;
  logic [TimeW-1:0] idx_time_q, idx_time_d;
  logic [TimeW-1:0] brake_start_q, brake_start_d;
  logic             enable_q, enable_d;
  logic [2:0]       lamp_q, lamp_d;
  logic             res_valid_q;
  res_t             res_q, res_d;

  logic             fire;
  logic [TimeW-1:0] now;
  logic [TimeW-1:0] edge_gap;
  logic [IntW-1:0]  gap_sat;
  logic [SumW-1:0]  decel_lhs;
  logic [SumW-1:0]  decel_rhs;
  logic [WideW-1:0] late_x3;
  logic [LockW-1:0] lock_sat;
  logic [LockW-1:0] lock_wide;
  logic [PosW-1:0]  pos_step;
  logic signed [PosW:0] pos_ext;
  logic signed [PosW:0] lim_ext;
  logic             swing_wide;
  logic             reverse;
  logic [TimeW-1:0] period_rem;
  logic             pump_high;
  logic             pump_hold;
  logic             pump_below;
  logic             swing_expired;
  logic             brake_expired;
  logic             index_settled;

  // A result register parts the two sides; an event is applied on transfer.
  assign item_ready_o = !res_valid_q || res_ready_i;
  assign fire         = item_i.valid && item_ready_o;
  assign now          = item_i.evt.time_ms;

  // Encoder edge: saturated interval and the shifted history.
  assign edge_gap = now - last_edge_q;
  assign gap_sat  = (edge_gap > TimeW'(IntCap)) ? IntCap : IntW'(edge_gap);

  always_comb begin
    for (int k = 0; k < HistDepth - 1; k++) begin
      hist_d[k] = hist_q[k];
    end
    hist_d[HistDepth-1] = hist_q[HistDepth-1];
    if (fire && item_i.evt.mode == MODE_EDGE) begin
      for (int k = 0; k < HistDepth - 1; k++) begin
        hist_d[k] = hist_q[k+1];
      end
      hist_d[HistDepth-1] = gap_sat;
    end
  end

  // Deceleration test on the shifted history: 5*early + 2 <= 2*late.
  assign decel_lhs = (SumW'(hist_q[1]) + SumW'(hist_q[2])) * SumW'(5) + SumW'(2);
  assign decel_rhs = (SumW'(hist_q[3]) + SumW'(hist_q[4]) + SumW'(gap_sat)) << 1;

  // Adaptive lockout from the late intervals, clamped to the 20-bit range
  // and to the configured minimum.
  assign late_x3   = (WideW'(hist_q[3]) + WideW'(hist_q[4]) + WideW'(gap_sat)) * WideW'(3);
  assign lock_sat  = (late_x3 > WideW'(LockMax)) ? LockMax : LockW'(late_x3);
  assign lock_wide = (lock_sat < LockW'(cfg_i.min_hold)) ? LockW'(cfg_i.min_hold) : lock_sat;

  // Position after the step and the wide-swing test on it.
  assign pos_step   = dir_q ? pos_q + PosW'(1) : pos_q - PosW'(1);
  assign pos_ext    = $signed({pos_step[PosW-1], pos_step});
  assign lim_ext    = $signed({2'b00, cfg_i.wide_limit});
  assign swing_wide = (pos_ext > lim_ext) || (pos_ext < -lim_ext);
  assign reverse    = ((now - last_rev_q) > TimeW'(lock_q)) && (decel_lhs <= decel_rhs);

  // Pump square wave: remainder of the timestamp by the period.
  assign period_rem = now - TimeW'(item_i.quo) * PumpPeriodMs;
  assign pump_high  = period_rem > PumpHalfMs;
  assign pump_hold  = (now - cfg_i.start_time) < StartHoldMs;
  assign pump_below = $signed(pos_q) < cfg_i.pump_target;

  // Phase timers and index debounce.
  assign swing_expired = (now - last_rev_q) > TimeW'(cfg_i.swing_timeout);
  assign brake_expired = (now - brake_start_q) > TimeW'(cfg_i.brake);
  assign index_settled = pend_q && ((now - idx_time_q) > IndexSettleMs);

  // Next state for one event.
  always_comb begin
    pos_d         = pos_q;
    dir_d         = dir_q;
    pin_d         = pin_q;
    last_edge_d   = last_edge_q;
    last_rev_d    = last_rev_q;
    lock_d        = lock_q;
    phase_d       = phase_q;
    pend_d        = pend_q;
    idx_time_d    = idx_time_q;
    brake_start_d = brake_start_q;
    enable_d      = enable_q;
    lamp_d        = lamp_q;
    if (fire) begin
      unique case (item_i.evt.mode)
        MODE_EDGE: begin
          pos_d = pos_step;
          if (reverse) begin
            lock_d     = swing_wide ? lock_wide : LockW'(cfg_i.min_hold);
            dir_d      = ~dir_q;
            pin_d      = ~pin_q;
            last_rev_d = now;
          end
          last_edge_d = now;
        end
        MODE_INDEX: begin
          if (item_i.evt.index_level) begin
            lamp_d[0]  = ~lamp_q[0];
            pend_d     = 1'b1;
            idx_time_d = now;
          end
        end
        MODE_TICK: begin
          unique case (phase_q)
            PH_PUMP: begin
              if (pump_below) begin
                pin_d = pump_hold ? 1'b0 : pump_high;
              end else begin
                phase_d    = PH_SWING;
                last_rev_d = last_edge_q;
                lamp_d[1]  = 1'b1;
              end
            end
            PH_SWING: begin
              if (swing_expired) begin
                phase_d       = PH_BRAKE;
                dir_d         = ~dir_d;
                pin_d         = ~pin_d;
                lamp_d[1]     = 1'b0;
                brake_start_d = now;
              end
            end
            PH_BRAKE: begin
              if (brake_expired) begin
                phase_d   = PH_DONE;
                enable_d  = 1'b0;
                pin_d     = 1'b0;
                lamp_d[2] = 1'b1;
              end
            end
            PH_DONE: begin
              phase_d = PH_DONE;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
          // Debounced index preset.
          if (index_settled) begin
            if (item_i.evt.index_level) begin
              pos_d = cfg_i.index_pos;
            end
            pend_d = 1'b0;
          end
          // The stop switch starts braking anew in any phase.
          if (item_i.evt.stop_pressed) begin
            phase_d       = PH_BRAKE;
            dir_d         = ~dir_d;
            pin_d         = ~pin_d;
            lamp_d[1]     = 1'b0;
            brake_start_d = now;
          end
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  // Result fields from the updated state.
  always_comb begin
    res_d.motor_enable = enable_d;
    res_d.motor_dir    = pin_d;
    res_d.led_swing    = lamp_d[1];
    res_d.led_done     = lamp_d[2];
    res_d.led_index    = lamp_d[0];
    res_d.position     = $signed(pos_d);
    res_d.phase        = phase_d;
    res_d.hold_time    = lock_d;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q         <= '0;
      dir_q         <= 1'b0;
      pin_q         <= 1'b0;
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= '0;
      end
      last_edge_q   <= '0;
      last_rev_q    <= '0;
      lock_q        <= LockRst;
      phase_q       <= PH_PUMP;
      pend_q        <= 1'b0;
      idx_time_q    <= '0;
      brake_start_q <= '0;
      enable_q      <= 1'b1;
      lamp_q        <= '0;
    end else begin
      pos_q         <= pos_d;
      dir_q         <= dir_d;
      pin_q         <= pin_d;
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= hist_d[k];
      end
      last_edge_q   <= last_edge_d;
      last_rev_q    <= last_rev_d;
      lock_q        <= lock_d;
      phase_q       <= phase_d;
      pend_q        <= pend_d;
      idx_time_q    <= idx_time_d;
      brake_start_q <= brake_start_d;
      enable_q      <= enable_d;
      lamp_q        <= lamp_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      res_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ hw/rtl/swing_reversal_motor_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Swing reversal motor sequencer
// Encoder, index and tick events in; motor enable, direction, lamps,
// position, phase and lockout out, one result per event.
// ----------------------------------------------------------------------------
// The block takes one event in every clock cycle unless the result channel
// stalls it, and returns exactly one result for it after its transfer has
// passed the input register, the reciprocal multiply that finds the
// timestamp's place in the 1200 ms pump period, and the state update that
// also loads the result register. Back-pressure on the result channel
// stalls the pipeline stage by stage, so empty stages keep taking events
// meanwhile. Configuration registers are written through a plain write
// port and take effect for events that reach the state update after the
// write; they are meant to be written while no event is in flight.
module swing_reversal_motor_sequencer_top
  import srms_pkg::*;
#(
  parameter int unsigned INTERVAL_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  srms_evt_if.sink            evt_i,
  srms_res_if.source          res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t  cfg;
  evt_t  in_evt;
  item_t item;
  logic  item_ready;
  res_t  res;

  // Event payload gathered from the channel.
  assign in_evt.mode         = mode_e'(evt_i.mode);
  assign in_evt.time_ms      = evt_i.time_ms;
  assign in_evt.index_level  = evt_i.index_level;
  assign in_evt.stop_pressed = evt_i.stop_pressed;

  srms_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  srms_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (evt_i.valid),
    .in_ready_o   (evt_i.ready),
    .in_evt_i     (in_evt),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  srms_core #(
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_i       (item),
    .item_ready_o (item_ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_o        (res)
  );

  // Result payload onto the channel.
  assign res_o.motor_enable = res.motor_enable;
  assign res_o.motor_dir    = res.motor_dir;
  assign res_o.led_swing    = res.led_swing;
  assign res_o.led_done     = res.led_done;
  assign res_o.led_index    = res.led_index;
  assign res_o.position     = res.position;
  assign res_o.phase        = res.phase;
  assign res_o.hold_time    = res.hold_time;

endmodule

@@ hw/rtl/srms_checker.sv @@
// ----------------------------------------------------------------------------
// Sequencer port checker
// Watches the channels of the sequencer top level and checks its
// transfer accounting and the shutdown behavior of the motor outputs.
// ----------------------------------------------------------------------------
module srms_checker
  import srms_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               evt_valid_i,
  input logic               evt_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic               motor_enable_i,
  input logic               led_done_i,
  input logic [1:0]         phase_i,
  input logic signed [15:0] position_i
);

  logic [1:0] inflight_q;
  logic       disabled_q;
  logic       evt_xfer;
  logic       res_xfer;

  assign evt_xfer = evt_valid_i && evt_ready_i;
  assign res_xfer = res_valid_i && res_ready_i;

  // Events transferred in whose results are not yet transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (evt_xfer && !res_xfer) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (res_xfer && !evt_xfer) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  // Set once a result has shown the motor disabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disabled_q <= 1'b0;
    end else if (res_xfer && !motor_enable_i) begin
      disabled_q <= 1'b1;
    end
  end

  // A result is only offered for an event that was taken.
  a_result_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> inflight_q != 2'd0)
    else $error("result offered with no event in flight");

  // The pipeline never holds more than three events, so a full pipeline
  // with a stalled output takes nothing.
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 2'd3 && !res_xfer) |-> !evt_xfer)
    else $error("event taken into a full pipeline");

  // Once disabled, the motor is never enabled again.
  a_enable_stays_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && disabled_q) |-> !motor_enable_i)
    else $error("motor enabled again after shutdown");

  // The done lamp only lights with the motor disabled and in done or brake.
  a_done_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && led_done_i) |->
      (!motor_enable_i && (phase_i == PH_DONE || phase_i == PH_BRAKE)))
    else $error("done lamp lit outside shutdown");

  // A stalled result holds its position.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(position_i)))
    else $error("stalled result changed");

endmodule

bind swing_reversal_motor_sequencer_top srms_checker u_srms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .evt_valid_i    (evt_i.valid),
  .evt_ready_i    (evt_i.ready),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .motor_enable_i (res_o.motor_enable),
  .led_done_i     (res_o.led_done),
  .phase_i        (res_o.phase),
  .position_i     (res_o.position)
);

@@ tb/sv/srms_sequencer_checker.sv @@
// ----------------------------------------------------------------------------
// Swing reversal motor sequencer checker
// Watches the event and result channels and the register write port. It keeps
// its own copy of the sequencer state, works out the expected outputs for
// each event transfer and compares every result transfer against them in order.
// ----------------------------------------------------------------------------
module srms_sequencer_checker
  import srms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  srms_evt_if                 evt_i,
  srms_res_if                 res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output int                  reversals_o
);

  localparam int unsigned IntervalBits = 16;
  localparam logic [IntervalBits-1:0] GapCap = '1;

  // Register settings as the sequencer sees them.
  logic [TimeW-1:0]       start_q;
  logic [HoldW-1:0]       min_hold_q;
  logic [HoldW-1:0]       swing_timeout_q;
  logic [HoldW-1:0]       brake_ms_q;
  logic signed [PosW-1:0] pump_target_q;
  logic [LimitW-1:0]      wide_limit_q;
  logic signed [PosW-1:0] index_pos_q;

  // Mirrored sequencer state.
  logic [PosW-1:0]         pos_q;
  logic                    travel_up;
  logic                    dir_pin;
  logic [IntervalBits-1:0] gaps [HistDepth];
  logic [TimeW-1:0]        last_edge_t;
  logic [TimeW-1:0]        last_rev_t;
  logic [TimeW-1:0]        pend_t;
  logic [TimeW-1:0]        brake_t;
  logic [LockW-1:0]        lockout_ms;
  phase_e                  phase_q;
  logic                    pend_q;
  logic                    enable_q;
  logic [2:0]              lamps;  // bit 0 index, bit 1 swing, bit 2 done

  // Outputs expected for events that have gone in but not come out yet.
  res_t pending_outputs [$];

  task automatic reset_sequencer();
    start_q         = StartTimeRst;
    min_hold_q      = MinHoldRst;
    swing_timeout_q = SwingTimeoutRst;
    brake_ms_q      = BrakeRst;
    pump_target_q   = PumpTargetRst;
    wide_limit_q    = WideLimitRst;
    index_pos_q     = IndexPosRst;
    pos_q           = '0;
    travel_up       = 1'b0;
    dir_pin         = 1'b0;
    for (int k = 0; k < HistDepth; k++) gaps[k] = '0;
    last_edge_t     = '0;
    last_rev_t      = '0;
    pend_t          = '0;
    brake_t         = '0;
    lockout_ms      = LockRst;
    phase_q         = PH_PUMP;
    pend_q          = 1'b0;
    enable_q        = 1'b1;
    lamps           = '0;
  endtask

  task automatic write_setting(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (cfg_reg_e'(idx))
      REG_START_TIME:    start_q         = data;
      REG_MIN_HOLD:      min_hold_q      = data[HoldW-1:0];
      REG_SWING_TIMEOUT: swing_timeout_q = data[HoldW-1:0];
      REG_BRAKE:         brake_ms_q      = data[HoldW-1:0];
      REG_PUMP_TARGET:   pump_target_q   = data[PosW-1:0];
      REG_WIDE_LIMIT:    wide_limit_q    = data[LimitW-1:0];
      REG_INDEX_POS:     index_pos_q     = data[PosW-1:0];
      default: ;
    endcase
  endtask

  // Braking flips the direction, drops the swing lamp and restarts the brake timer.
  task automatic start_braking(input logic [TimeW-1:0] now);
    phase_q   = PH_BRAKE;
    travel_up = ~travel_up;
    dir_pin   = ~dir_pin;
    lamps[1]  = 1'b0;
    brake_t   = now;
  endtask

  // An encoder edge steps the position and may reverse on deceleration.
  task automatic encoder_step(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] since;
    longint unsigned  early;
    longint unsigned  late;
    longint unsigned  lock;
    int               p;
    pos_q = travel_up ? pos_q + 1'b1 : pos_q - 1'b1;
    since = now - last_edge_t;
    for (int k = 0; k < HistDepth - 1; k++) gaps[k] = gaps[k+1];
    gaps[HistDepth-1] = (since > GapCap) ? GapCap : since[IntervalBits-1:0];
    early = gaps[0] + gaps[1];
    late  = gaps[2] + gaps[3] + gaps[4];
    if ((now - last_rev_t) > lockout_ms && 5 * early + 2 <= 2 * late) begin
      p = $signed(pos_q);
      if (p > int'(wide_limit_q) || p < -int'(wide_limit_q)) begin
        lock = 3 * late;
        if (lock > LockMax) lock = LockMax;
        if (lock < min_hold_q) lock = min_hold_q;
        lockout_ms = lock[LockW-1:0];
      end else begin
        lockout_ms = min_hold_q;
      end
      travel_up   = ~travel_up;
      dir_pin     = ~dir_pin;
      last_rev_t  = now;
      reversals_o = reversals_o + 1;
    end
    last_edge_t = now;
  endtask

  // A tick advances the phase, settles a pending index and samples the stop switch.
  task automatic tick_step(input logic [TimeW-1:0] now, input logic lvl, input logic stop);
    case (phase_q)
      PH_PUMP: begin
        if ($signed(pos_q) < pump_target_q) begin
          if (now - start_q < StartHoldMs) dir_pin = 1'b0;
          else dir_pin = (now % PumpPeriodMs) > PumpHalfMs;
        end else begin
          phase_q    = PH_SWING;
          last_rev_t = last_edge_t;
          lamps[1]   = 1'b1;
        end
      end
      PH_SWING: begin
        if ((now - last_rev_t) > swing_timeout_q) start_braking(now);
      end
      PH_BRAKE: begin
        if ((now - brake_t) > brake_ms_q) begin
          phase_q  = PH_DONE;
          enable_q = 1'b0;
          dir_pin  = 1'b0;
          lamps[2] = 1'b1;
        end
      end
      default: ;
    endcase
    if (pend_q && (now - pend_t) > IndexSettleMs) begin
      if (lvl) pos_q = index_pos_q;
      pend_q = 1'b0;
    end
    if (stop) start_braking(now);
  endtask

  task automatic advance_sequencer(input mode_e mode, input logic [TimeW-1:0] now,
                                   input logic lvl, input logic stop, output res_t outs);
    case (mode)
      MODE_EDGE: encoder_step(now);
      MODE_INDEX: begin
        if (lvl) begin
          lamps[0] = ~lamps[0];
          pend_q   = 1'b1;
          pend_t   = now;
        end
      end
      MODE_TICK: tick_step(now, lvl, stop);
      default: ;
    endcase
    outs.motor_enable = enable_q;
    outs.motor_dir    = dir_pin;
    outs.led_swing    = lamps[1];
    outs.led_done     = lamps[2];
    outs.led_index    = lamps[0];
    outs.position     = pos_q;
    outs.phase        = phase_q;
    outs.hold_time    = lockout_ms;
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      fail_count_o = fail_count_o + 1;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  // Results are compared before the same edge's event is predicted, so a
  // transfer on both channels at once is handled in order.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t want;
    if (!rst_ni) begin
      reset_sequencer();
      pending_outputs.delete();
      pending_o    <= 0;
      fail_count_o = 0;
      checked_o    = 0;
      reversals_o  = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (pending_outputs.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: result transfer with no event outstanding", $time);
        end else begin
          want = pending_outputs.pop_front();
          check_field("motor_enable", want.motor_enable, res_i.motor_enable);
          check_field("motor_dir", want.motor_dir, res_i.motor_dir);
          check_field("led_swing", want.led_swing, res_i.led_swing);
          check_field("led_done", want.led_done, res_i.led_done);
          check_field("led_index", want.led_index, res_i.led_index);
          check_field("position", $signed(want.position), $signed(res_i.position));
          check_field("phase", want.phase, res_i.phase);
          check_field("hold_time", want.hold_time, res_i.hold_time);
          checked_o = checked_o + 1;
        end
      end
      if (cfg_we_i) write_setting(cfg_idx_i, cfg_data_i);
      if (evt_i.valid && evt_i.ready) begin
        advance_sequencer(mode_e'(evt_i.mode), evt_i.time_ms, evt_i.index_level,
                          evt_i.stop_pressed, want);
        pending_outputs.push_back(want);
      end
      pending_o <= pending_outputs.size();
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Swing reversal motor sequencer testbench
// Drives timestamped encoder, index and tick events through the sequencer
// under several register settings, with random idle cycles on both channels
// and two long result stalls, and leaves the checking to the checker beside it.
// ----------------------------------------------------------------------------
module testbench;
  import srms_pkg::*;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned HoldOffCycles = 200;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int pending;
  int fail_count;
  int checked;
  int reversals;

  bit [31:0] clock_ms;
  int        events_sent;
  int        settings_written;
  bit        steady;
  bit        hold_off_req;

  srms_evt_if evt_ch ();
  srms_res_if res_ch ();

  swing_reversal_motor_sequencer_top u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .evt_i      (evt_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  srms_sequencer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .evt_i        (evt_ch),
    .res_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .reversals_o  (reversals)
  );

  always #10 clk = ~clk;

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Time step between events: mostly small, sometimes past the interval
  // saturation, rarely anywhere in the 32-bit range.
  function automatic bit [31:0] rand_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 50);
    if (r < 90) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  // One event transfer; valid stays high when no idle gap comes before it.
  task automatic send_evt(input mode_e m, input bit [31:0] t, input bit lvl, input bit stp);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt_ch.valid        <= 1'b1;
    evt_ch.mode         <= m;
    evt_ch.time_ms      <= t;
    evt_ch.index_level  <= lvl;
    evt_ch.stop_pressed <= stp;
    @(posedge clk);
    while (!evt_ch.ready) @(posedge clk);
  endtask

  task automatic emit(input mode_e m, input bit [31:0] dt, input bit lvl, input bit stp);
    clock_ms = clock_ms + dt;
    send_evt(m, clock_ms, lvl, stp);
    if (m != MODE_NONE && !(m == MODE_INDEX && !lvl)) events_sent++;
  endtask

  task automatic emit_at(input mode_e m, input bit [31:0] t, input bit lvl, input bit stp);
    clock_ms = t;
    emit(m, 0, lvl, stp);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    evt_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input bit [31:0] start_v, hold_v, timeout_v, brake_v,
                              target_v, limit_v, index_v);
    bit [31:0] vals [7];
    vals[0] = start_v;
    vals[1] = hold_v;
    vals[2] = timeout_v;
    vals[3] = brake_v;
    vals[4] = target_v;
    vals[5] = limit_v;
    vals[6] = index_v;
    cfg_we <= 1'b1;
    for (int i = 0; i < 7; i++) begin
      cfg_idx  <= cfg_reg_e'(i);
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  // Half a pendulum swing: edge intervals shrink, then grow again so that
  // deceleration shows at the end, with ticks mixed in.
  task automatic swing_burst(input bit allow_stop);
    int len;
    int base;
    int slope;
    int mid;
    int span;
    len   = $urandom_range(6, 16);
    base  = $urandom_range(1, 30);
    slope = $urandom_range(0, 12);
    mid   = len / 2;
    for (int i = 0; i < len; i++) begin
      span = (i > mid) ? i - mid : mid - i;
      emit(MODE_EDGE, base + slope * span, 1'($urandom_range(0, 1)),
           1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0)
        emit(MODE_TICK, $urandom_range(0, 5), 1'($urandom_range(0, 1)),
             allow_stop && ($urandom_range(0, 15) == 0));
    end
  endtask

  // A rising index edge, then a tick around the settle time.
  task automatic index_probe(input bit allow_stop);
    emit(MODE_INDEX, $urandom_range(0, 20), 1'b1, 1'($urandom_range(0, 1)));
    emit(MODE_TICK, $urandom_range(0, 3), 1'($urandom_range(0, 1)),
         allow_stop && ($urandom_range(0, 7) == 0));
  endtask

  task automatic noise_item(input bit allow_stop);
    emit(mode_e'($urandom_range(0, 3)), rand_step(), 1'($urandom_range(0, 1)),
         allow_stop && ($urandom_range(0, 3) == 0));
  endtask

  task automatic run_segment(input int target, input bit allow_stop);
    int stop_at;
    int pick;
    stop_at = events_sent + target;
    while (events_sent < stop_at) begin
      steady = ($urandom_range(0, 7) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 65) swing_burst(allow_stop);
      else if (pick < 80) index_probe(allow_stop);
      else noise_item(allow_stop);
    end
    steady = 1'b0;
    drain();
  endtask

  // Result side: random stalls, plus one long hold-off whenever requested.
  initial begin : result_sink
    int stall;
    int run;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        stall = steady ? 0 : idle_len();
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      run = steady ? 32 : $urandom_range(1, 6);
      repeat (run) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("swing_reversal_motor_sequencer_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    evt_ch.valid        <= 1'b0;
    evt_ch.mode         <= MODE_NONE;
    evt_ch.time_ms      <= '0;
    evt_ch.index_level  <= 1'b0;
    evt_ch.stop_pressed <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= REG_START_TIME;
    cfg_data            <= '0;
    clock_ms         = '0;
    events_sent      = 0;
    settings_written = 0;
    steady           = 1'b0;
    hold_off_req     = 1'b0;
    rst_n            = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed events at the reset settings: unused mode, pump hold and
    // square wave edges, index settle and preset, reversal, saturated
    // intervals and the timestamp wrap.
    emit_at(MODE_NONE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    emit_at(MODE_TICK, 32'd0, 1'b0, 1'b0);
    emit_at(MODE_EDGE, 32'd0, 1'b1, 1'b1);
    emit_at(MODE_TICK, 32'd1800, 1'b0, 1'b0);
    emit_at(MODE_TICK, 32'd1801, 1'b1, 1'b0);
    emit_at(MODE_INDEX, 32'd2000, 1'b0, 1'b1);
    emit_at(MODE_INDEX, 32'd2000, 1'b1, 1'b0);
    emit_at(MODE_TICK, 32'd2001, 1'b1, 1'b0);
    emit_at(MODE_TICK, 32'd2002, 1'b0, 1'b0);
    emit_at(MODE_INDEX, 32'd2100, 1'b1, 1'b0);
    emit_at(MODE_TICK, 32'd2105, 1'b1, 1'b0);
    emit_at(MODE_EDGE, 32'd2200, 1'b0, 1'b0);
    emit_at(MODE_EDGE, 32'd2201, 1'b0, 1'b0);
    emit_at(MODE_EDGE, 32'd2202, 1'b1, 1'b0);
    emit_at(MODE_EDGE, 32'd72300, 1'b0, 1'b1);
    emit_at(MODE_TICK, 32'd72301, 1'b0, 1'b0);
    emit_at(MODE_NONE, 32'd0, 1'b0, 1'b0);
    emit_at(MODE_EDGE, 32'hFFFF_FFFF, 1'b1, 1'b1);
    emit_at(MODE_EDGE, 32'd5, 1'b0, 1'b0);
    emit_at(MODE_TICK, 32'd700, 1'b0, 1'b0);
    drain();

    // Pumping: the target is out of reach, so only the pump wave runs.
    program_regs(clock_ms, $urandom_range(50, 600), 32'h0000_FFFF, 32'd3000,
                 32'h0000_7FFF, 32'h0000_7FFF, $urandom_range(0, 20));
    run_segment(200, 1'b0);

    // Swinging with the lowest target, no minimum hold and a zero wide limit,
    // while the result side holds off once for a long stretch.
    clock_ms = $urandom;
    program_regs(clock_ms, 32'd0, 32'h0000_FFFF, $urandom_range(100, 2000),
                 32'h0000_8000, 32'd0, 32'h0000_8000);
    hold_off_req = 1'b1;
    run_segment(200, 1'b0);

    // Longest minimum hold and a finite timeout, so braking and done follow.
    program_regs($urandom, 32'h0000_FFFF, $urandom_range(1500, 8000),
                 $urandom_range(0, 4000), $urandom_range(0, 65535),
                 $urandom_range(0, 60), 32'h0000_7FFF);
    run_segment(150, 1'b0);

    // No timeout or brake time, stop switch in use.
    program_regs(32'd0, $urandom_range(0, 1000), 32'd0, 32'd0, $urandom_range(0, 65535),
                 $urandom_range(0, 32767), $urandom_range(0, 65535));
    hold_off_req = 1'b1;
    run_segment(100, 1'b1);

    // Random settings at the far end of the ranges.
    program_regs(32'hFFFF_FFFF, $urandom_range(0, 65535), $urandom_range(0, 65535),
                 32'h0000_FFFF, $urandom_range(0, 65535), $urandom_range(0, 32767),
                 $urandom_range(0, 65535));
    run_segment(100, 1'b1);

    repeat (8) @(posedge clk);
    $display("Sent %0d events under %0d register settings.", events_sent, settings_written);
    $display("Checked %0d results, %0d direction reversals, %0d failures.",
             checked, reversals, fail_count);
    if (fail_count == 0) begin
      $display("swing_reversal_motor_sequencer_top: match");
    end else begin
      $display("swing_reversal_motor_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule

@@ swing_reversal_motor_sequencer_top.f @@
hw/rtl/srms_pkg.sv
hw/rtl/srms_evt_if.sv
hw/rtl/srms_res_if.sv
hw/rtl/srms_cfg_regs.sv
hw/rtl/srms_front.sv
hw/rtl/srms_core.sv
hw/rtl/swing_reversal_motor_sequencer_top.sv
hw/rtl/srms_checker.sv
tb/sv/srms_sequencer_checker.sv
tb/sv/testbench.sv
